// ===== rtl/fixed_size_pool_allocator_top_macros.svh =====
// Assertion helpers shared by the allocator modules.
`ifndef FIXED_SIZE_POOL_ALLOCATOR_TOP_MACROS_SVH
`define FIXED_SIZE_POOL_ALLOCATOR_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define FSPA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define FSPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/fspa_pkg.sv =====
`default_nettype none
package fspa_pkg;

  localparam int MAX_CHUNKS_DEF = 8;
  localparam int FREE_DEPTH_DEF = 256;

  localparam int OFF_W   = 29;
  localparam int CHUNK_W = 3;
  localparam int ST_W    = 3;
  localparam int FCE_W   = 11;
  localparam int EB_W    = 13;
  localparam int RSIZE_W = 14;
  localparam int PROD_W  = FCE_W + RSIZE_W;
  localparam int ACT_W   = 4;
  localparam int CAP_W   = OFF_W + 1;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [CAP_W-1:0] OFF_SPAN = CAP_W'(1) << OFF_W;

  localparam logic [FCE_W-1:0] FCE_RST = FCE_W'(8);
  localparam logic [EB_W-1:0]  EB_RST  = EB_W'(8);

  // Register indexes, taken from paddr[2].
  localparam logic REG_FCE = 1'b0;
  localparam logic REG_EB  = 1'b1;

  localparam logic [ST_W-1:0] ST_GRANTED   = 3'd0;
  localparam logic [ST_W-1:0] ST_EXHAUSTED = 3'd1;
  localparam logic [ST_W-1:0] ST_RECYCLED  = 3'd2;
  localparam logic [ST_W-1:0] ST_NULL      = 3'd3;
  localparam logic [ST_W-1:0] ST_OVERFLOW  = 3'd4;

  typedef struct packed {
    logic load;
    logic exec;
    logic send;
  } cmd_t;

endpackage
`default_nettype wire

// ===== rtl/fspa_ctrl.sv =====
`default_nettype none
`include "fixed_size_pool_allocator_top_macros.svh"
module fspa_ctrl
  import fspa_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire logic out_free,
  output cmd_t      cmd
);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_SEND} state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r;

  assign in_ready = in_ready_r;

  always_comb begin
    cmd.load  = in_valid && in_ready_r;
    cmd.exec  = (state_r == S_EXEC);
    cmd.send  = (state_r == S_SEND) && out_free;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.load) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_SEND;
      end
      S_SEND: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_ready_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= (state_nxt == S_IDLE);
    end
  end

  `FSPA_ASSERT_SAME(a_ready_idle, in_ready_r, state_r == S_IDLE, "ready outside idle")
  `FSPA_ASSERT_NEXT(a_load_exec, cmd.load, state_r == S_EXEC, "transaction not executed")

endmodule
`default_nettype wire

// ===== rtl/fspa_dp.sv =====
`default_nettype none
`include "fixed_size_pool_allocator_top_macros.svh"
module fspa_dp
  import fspa_pkg::*;
#(
  parameter int MAX_CHUNKS = MAX_CHUNKS_DEF,
  parameter int FREE_DEPTH = FREE_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cmd_t               cmd,
  input  wire logic [FCE_W-1:0]   first_chunk_elements,
  input  wire logic [EB_W-1:0]    element_bytes,
  input  wire logic               in_mode,
  input  wire logic [CHUNK_W-1:0] in_chunk_index,
  input  wire logic [OFF_W-1:0]   in_byte_offset,
  input  wire logic               in_element_null,
  input  wire logic               out_ready,
  output logic                    out_free,
  output logic                    out_valid,
  output logic [ST_W-1:0]         out_status,
  output logic [CHUNK_W-1:0]      out_given_chunk,
  output logic [OFF_W-1:0]        out_given_offset
);

  localparam int AW = (FREE_DEPTH > 1) ? $clog2(FREE_DEPTH) : 1;
  localparam int CW = $clog2(FREE_DEPTH + 1);

  logic [CHUNK_W+OFF_W-1:0] mem [FREE_DEPTH];
  logic [CHUNK_W+OFF_W-1:0] rd_data_r;

  logic               mode_r, null_r;
  logic [CHUNK_W-1:0] chunk_r;
  logic [OFF_W-1:0]   off_r;

  logic [CW-1:0]      free_count_r, free_count_nxt;
  logic [ACT_W-1:0]   active_chunk_r, active_chunk_nxt;
  logic               chunk_open_r, chunk_open_nxt;
  logic [OFF_W-1:0]   bump_r, bump_nxt;

  logic [PROD_W-1:0]  prod_r;
  logic [RSIZE_W-1:0] size_sum, rsize;

  logic [ST_W-1:0]    res_status_r, res_status_nxt;
  logic [CHUNK_W-1:0] res_chunk_r, res_chunk_nxt;
  logic [OFF_W-1:0]   res_off_r, res_off_nxt;

  logic               out_valid_r;
  logic [ST_W-1:0]    out_status_r;
  logic [CHUNK_W-1:0] out_chunk_r;
  logic [OFF_W-1:0]   out_off_r;

  logic               push_en;
  logic [CW-1:0]      cnt_dec;

  assign size_sum = {1'b0, element_bytes} + RSIZE_W'(7);
  assign rsize    = {size_sum[RSIZE_W-1:3], 3'b000};
  assign cnt_dec  = free_count_r - CW'(1);

  // Chunk-zero capacity in bytes; later chunks shift it by the chunk number.
  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(first_chunk_elements) * PROD_W'(rsize);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r  <= in_mode;
      chunk_r <= in_chunk_index;
      off_r   <= in_byte_offset;
      null_r  <= in_element_null;
    end
  end

  // Free stack: the top entry is read when the transaction is accepted.
  always_ff @(posedge clk) begin
    if (cmd.load) rd_data_r <= mem[cnt_dec[AW-1:0]];
    if (push_en) mem[free_count_r[AW-1:0]] <= {chunk_r, off_r};
  end

  always_comb begin
    logic [31:0]        shifted;
    logic [CAP_W-1:0]   cap;
    logic [CAP_W-1:0]   next_off;
    logic [ACT_W-1:0]   act_inc;

    shifted  = 32'(prod_r) << active_chunk_r[2:0];
    cap      = (shifted > 32'(OFF_SPAN)) ? OFF_SPAN : shifted[CAP_W-1:0];
    next_off = {1'b0, bump_r} + CAP_W'(rsize);
    act_inc  = active_chunk_r + ACT_W'(1);

    push_en          = 1'b0;
    free_count_nxt   = free_count_r;
    active_chunk_nxt = active_chunk_r;
    chunk_open_nxt   = chunk_open_r;
    bump_nxt         = bump_r;
    res_status_nxt   = ST_GRANTED;
    res_chunk_nxt    = '0;
    res_off_nxt      = '0;

    if (mode_r) begin
      if (null_r) begin
        res_status_nxt = ST_NULL;
      end else if (free_count_r >= CW'(FREE_DEPTH)) begin
        res_status_nxt = ST_OVERFLOW;
      end else begin
        push_en        = cmd.exec;
        free_count_nxt = free_count_r + CW'(1);
        res_status_nxt = ST_RECYCLED;
      end
    end else if (free_count_r != '0) begin
      free_count_nxt = cnt_dec;
      res_chunk_nxt  = rd_data_r[CHUNK_W+OFF_W-1:OFF_W];
      res_off_nxt    = rd_data_r[OFF_W-1:0];
    end else if (!chunk_open_r) begin
      chunk_open_nxt   = 1'b1;
      active_chunk_nxt = '0;
      bump_nxt         = '0;
    end else if (active_chunk_r >= ACT_W'(MAX_CHUNKS)) begin
      res_status_nxt = ST_EXHAUSTED;
    end else if (next_off >= cap) begin
      if (act_inc >= ACT_W'(MAX_CHUNKS)) begin
        active_chunk_nxt = ACT_W'(MAX_CHUNKS);
        res_status_nxt   = ST_EXHAUSTED;
      end else begin
        active_chunk_nxt = act_inc;
        bump_nxt         = '0;
        res_chunk_nxt    = act_inc[CHUNK_W-1:0];
      end
    end else begin
      bump_nxt      = next_off[OFF_W-1:0];
      res_chunk_nxt = active_chunk_r[CHUNK_W-1:0];
      res_off_nxt   = next_off[OFF_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_count_r   <= '0;
      active_chunk_r <= '0;
      chunk_open_r   <= 1'b0;
      bump_r         <= '0;
    end else if (cmd.exec) begin
      free_count_r   <= free_count_nxt;
      active_chunk_r <= active_chunk_nxt;
      chunk_open_r   <= chunk_open_nxt;
      bump_r         <= bump_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_status_r <= res_status_nxt;
      res_chunk_r  <= res_chunk_nxt;
      res_off_r    <= res_off_nxt;
    end
  end

  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.send) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.send) begin
      out_status_r <= res_status_r;
      out_chunk_r  <= res_chunk_r;
      out_off_r    <= res_off_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_given_chunk  = out_chunk_r;
  assign out_given_offset = out_off_r;

  `FSPA_ASSERT_SAME(a_cnt_range, 1'b1, free_count_r <= CW'(FREE_DEPTH), "free count overrun")
  `FSPA_ASSERT_SAME(a_closed_clear, !chunk_open_r, active_chunk_r == '0 && bump_r == '0, "closed pool moved")
  `FSPA_ASSERT_NEXT(a_cnt_hold, !cmd.exec, $stable(free_count_r), "free count moved while idle")

endmodule
`default_nettype wire

// ===== rtl/fixed_size_pool_allocator_top.sv =====
// Fixed-size pool allocator.
// Input channel (in_valid/in_ready): a get (in_mode 0) or a recycle (in_mode 1) of
// a slot given as chunk number and byte offset; in_element_null marks a null slot.
// Output channel (out_valid/out_ready): one result per transaction with a status
// code and, for a grant, the chunk and byte offset of the slot.
// A get pops the free stack first, otherwise it bumps through the open chunk and
// opens the next one when it fills; after the last chunk it reports exhausted.
// A transaction passes through accept plus free-stack read, an execute step
// with the capacity add and compare, and a load of the output register.
// A new transaction is accepted only once the last one has been sent.
// If the receiver stalls, the finished result waits in the output register; the
// next transaction executes and then waits in the send stage until the register
// frees, and in_ready stays low meanwhile.
// Reset (rst_n low, synchronous) empties the free stack, closes all chunks and
// restores both configuration registers to 8; the stack memory is not cleared.
// Config registers 0 and 1 sit at APB addresses 0 and 4; the user must write
// them only while no transaction is in flight, as the block does not check it.
`default_nettype none
module fixed_size_pool_allocator_top
  import fspa_pkg::*;
#(
  parameter int MAX_CHUNKS = MAX_CHUNKS_DEF,
  parameter int FREE_DEPTH = FREE_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_mode,
  input  wire logic [CHUNK_W-1:0] in_chunk_index,
  input  wire logic [OFF_W-1:0]   in_byte_offset,
  input  wire logic               in_element_null,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [ST_W-1:0]         out_status,
  output logic [CHUNK_W-1:0]      out_given_chunk,
  output logic [OFF_W-1:0]        out_given_offset
);

  logic [FCE_W-1:0] fce_r;
  logic [EB_W-1:0]  eb_r;
  logic             cfg_wr;
  logic             out_free;
  cmd_t             cmd;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fce_r <= FCE_RST;
      eb_r  <= EB_RST;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_FCE: fce_r <= pwdata[FCE_W-1:0];
        REG_EB:  eb_r  <= pwdata[EB_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_FCE: prdata = PDATA_W'(fce_r);
      REG_EB:  prdata = PDATA_W'(eb_r);
      default: prdata = '0;
    endcase
  end

  fspa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_free (out_free),
    .cmd      (cmd)
  );

  fspa_dp #(
    .MAX_CHUNKS (MAX_CHUNKS),
    .FREE_DEPTH (FREE_DEPTH)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .first_chunk_elements (fce_r),
    .element_bytes        (eb_r),
    .in_mode              (in_mode),
    .in_chunk_index       (in_chunk_index),
    .in_byte_offset       (in_byte_offset),
    .in_element_null      (in_element_null),
    .out_ready            (out_ready),
    .out_free             (out_free),
    .out_valid            (out_valid),
    .out_status           (out_status),
    .out_given_chunk      (out_given_chunk),
    .out_given_offset     (out_given_offset)
  );

endmodule
`default_nettype wire
